>>> hw/rtl/hsc_pkg.sv
package hsc_pkg;

  localparam int TIME_BITS_DEF       = 48;
  localparam int VALUE_FRAC_BITS_DEF = 16;

  localparam int VALUE_W = 32;
  localparam int STIME_W = 48;
  localparam int COUNT_W = 32;
  localparam int DB_W    = 31;
  localparam int CFG_W   = 32;
  localparam int SLOPE_W = 64;
  // |value difference +/- deadband| fits in 33 bits
  localparam int MAG_W   = 33;

  localparam logic [31:0] MAX_INTERVAL_RST = 32'd60000;

  localparam logic [1:0] MODE_ALL     = 2'd0;
  localparam logic [1:0] MODE_DOOR    = 2'd1;
  localparam logic [1:0] MODE_DEADB   = 2'd2;
  localparam logic [1:0] MODE_DEADB_T = 2'd3;

  localparam logic [1:0] KIND_JUDGE = 2'd0;
  localparam logic [1:0] KIND_FORCE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_DEADBAND = 2'd1;
  localparam logic [1:0] REG_MAX_INT  = 2'd2;

endpackage

>>> hw/rtl/hsc_div.sv
module hsc_div #(
  parameter int DW = 49,
  parameter int VW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    dsr_r, dsr_nxt;
  logic [VW:0]      shifted;
  logic [VW:0]      trial;

  // restoring, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r, quo_r[DW-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (busy_r) begin
      if (!trial[VW]) begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/historian_sample_compression.sv
// channel | dir | signals                          | payload
// in      | in  | in_tvalid/in_tready              | tuser: kind; tdata: value, time
// out     | out | out_tvalid/out_tready            | tuser: store; tdata: value, time,
//         |     |                                  |   count_in, count_out
// cfg     | in  | cfg_we/cfg_index/cfg_wdata       | mode, deadband, max_interval_ms
// Swinging-door judge items (door mode, not awaiting a kept sample, nonzero time step)
// pass from EVAL through DIVU and DIVL, two passes through the shared bit-serial divider,
// to WRITE, which loads the result register; all other items go from EVAL to WRITE. WRITE
// waits while an untaken result is held. in_tready rises with the result load.
// Synchronous active-low reset; state returns to reset values, no clearing pass.
// in_tready is high only when the sequencer is idle; one result register lets
// the next item be taken while a result waits on out_tready.
module historian_sample_compression
  import hsc_pkg::*;
#(
  parameter int TIME_BITS       = TIME_BITS_DEF,
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,   // [31:0] sample_value, [79:32] sample_time
  input  logic [1:0]    in_tuser,   // [1:0] kind
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,  // [31:0] out_value, [79:32] out_time,
                                    // [111:80] count_in, [143:112] count_out
  output logic [0:0]    out_tuser,  // [0] store
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SLOPE_SHIFT = 32 - VALUE_FRAC_BITS;
  localparam int DW          = MAG_W + SLOPE_SHIFT;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIVU, S_DIVL, S_WRITE} state_t;

  state_t state_r, state_nxt;

  logic [1:0]          mode_r, mode_nxt;
  logic [DB_W-1:0]     deadband_r, deadband_nxt;
  logic [31:0]         max_int_r, max_int_nxt;

  logic [1:0]          kind_r, kind_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [STIME_W-1:0]  stime_r, stime_nxt;
  logic                st_r, st_nxt;

  logic                await_r, await_nxt;
  logic [VALUE_W-1:0]  kept_value_r, kept_value_nxt;
  logic [TIME_BITS-1:0] kept_time_r, kept_time_nxt;
  logic signed [SLOPE_W-1:0] upper_r, upper_nxt;
  logic signed [SLOPE_W-1:0] lower_r, lower_nxt;
  logic signed [SLOPE_W-1:0] su_r, su_nxt;
  logic [COUNT_W-1:0]  seen_r, seen_nxt;
  logic [COUNT_W-1:0]  stored_r, stored_nxt;

  logic                out_tvalid_r, out_tvalid_nxt;
  logic [143:0]        out_tdata_r, out_tdata_nxt;
  logic                out_store_r, out_store_nxt;

  logic [TIME_BITS-1:0] t_cur;
  logic [TIME_BITS-1:0] dt;
  logic [32:0]         diff;
  logic [32:0]         dev;
  logic [33:0]         num_u, num_l, abs_u, abs_l;
  logic                neg_u, neg_l;
  logic [DW-1:0]       dvd_u, dvd_l;
  logic [SLOPE_W-1:0]  q64;
  logic signed [SLOPE_W-1:0] slope_new, new_up, new_lo;
  logic                start_lower;

  logic                div_start;
  logic                div_done;
  logic [DW-1:0]       div_quo;

  assign t_cur = TIME_BITS'(stime_r);
  assign dt    = t_cur - kept_time_r;
  assign diff  = {value_r[VALUE_W-1], value_r} - {kept_value_r[VALUE_W-1], kept_value_r};
  assign dev   = diff[32] ? (33'd0 - diff) : diff;
  assign num_u = {diff[32], diff} + {3'b000, deadband_r};
  assign num_l = {diff[32], diff} - {3'b000, deadband_r};
  assign neg_u = num_u[33];
  assign neg_l = num_l[33];
  assign abs_u = neg_u ? (34'd0 - num_u) : num_u;
  assign abs_l = neg_l ? (34'd0 - num_l) : num_l;
  assign dvd_u = DW'(abs_u[MAG_W-1:0]) << SLOPE_SHIFT;
  assign dvd_l = DW'(abs_l[MAG_W-1:0]) << SLOPE_SHIFT;

  assign q64       = SLOPE_W'(div_quo);
  assign slope_new = (state_r == S_DIVL ? neg_l : neg_u) ? $signed(-q64) : $signed(q64);
  assign new_up    = (su_r < upper_r) ? su_r : upper_r;
  assign new_lo    = (slope_new > lower_r) ? slope_new : lower_r;

  hsc_div #(
    .DW (DW),
    .VW (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (start_lower ? dvd_l : dvd_u),
    .divisor  (dt),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    deadband_nxt   = deadband_r;
    max_int_nxt    = max_int_r;
    kind_nxt       = kind_r;
    value_nxt      = value_r;
    stime_nxt      = stime_r;
    st_nxt         = st_r;
    await_nxt      = await_r;
    kept_value_nxt = kept_value_r;
    kept_time_nxt  = kept_time_r;
    upper_nxt      = upper_r;
    lower_nxt      = lower_r;
    su_nxt         = su_r;
    seen_nxt       = seen_r;
    stored_nxt     = stored_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_store_nxt  = out_store_r;
    div_start      = 1'b0;
    start_lower    = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     mode_nxt     = cfg_wdata[1:0];
        REG_DEADBAND: deadband_nxt = cfg_wdata[DB_W-1:0];
        REG_MAX_INT:  max_int_nxt  = cfg_wdata[31:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          value_nxt = in_tdata[31:0];
          stime_nxt = in_tdata[79:32];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        st_nxt    = 1'b0;
        state_nxt = S_WRITE;
        case (kind_r)
          KIND_JUDGE: begin
            seen_nxt = seen_r + 1'b1;
            if (mode_r == MODE_ALL) begin
              st_nxt = 1'b1;
            end else if (await_r) begin
              st_nxt = 1'b1;
            end else if (mode_r == MODE_DOOR) begin
              if (dt != '0) begin
                div_start = 1'b1;
                state_nxt = S_DIVU;
              end
            end else if (dev > {2'b00, deadband_r} ||
                         (mode_r == MODE_DEADB_T && dt >= TIME_BITS'(max_int_r))) begin
              st_nxt = 1'b1;
            end
            if (mode_r != MODE_ALL && st_nxt) begin
              kept_value_nxt = value_r;
              kept_time_nxt  = t_cur;
              await_nxt      = 1'b0;
            end
            if (st_nxt) stored_nxt = stored_r + 1'b1;
          end
          KIND_FORCE: begin
            kept_value_nxt = value_r;
            kept_time_nxt  = t_cur;
            await_nxt      = 1'b0;
            upper_nxt      = '0;
            lower_nxt      = '0;
            seen_nxt       = seen_r + 1'b1;
            stored_nxt     = stored_r + 1'b1;
            st_nxt         = 1'b1;
          end
          KIND_CLEAR: begin
            await_nxt      = 1'b1;
            kept_value_nxt = '0;
            kept_time_nxt  = '0;
            upper_nxt      = '0;
            lower_nxt      = '0;
            seen_nxt       = '0;
            stored_nxt     = '0;
          end
          default: ;
        endcase
      end
      S_DIVU: begin
        if (div_done) begin
          su_nxt      = slope_new;
          div_start   = 1'b1;
          start_lower = 1'b1;
          state_nxt   = S_DIVL;
        end
      end
      S_DIVL: begin
        if (div_done) begin
          state_nxt = S_WRITE;
          if (upper_r == '0 && lower_r == '0) begin
            upper_nxt = su_r;
            lower_nxt = slope_new;
          end else if (new_up >= new_lo) begin
            upper_nxt = new_up;
            lower_nxt = new_lo;
          end else begin
            kept_value_nxt = value_r;
            kept_time_nxt  = t_cur;
            await_nxt      = 1'b0;
            upper_nxt      = '0;
            lower_nxt      = '0;
            stored_nxt     = stored_r + 1'b1;
            st_nxt         = 1'b1;
          end
        end
      end
      S_WRITE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {stored_r, seen_r, stime_r, value_r};
          out_store_nxt  = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_ALL;
      deadband_r   <= '0;
      max_int_r    <= MAX_INTERVAL_RST;
      await_r      <= 1'b1;
      kept_value_r <= '0;
      kept_time_r  <= '0;
      upper_r      <= '0;
      lower_r      <= '0;
      seen_r       <= '0;
      stored_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      deadband_r   <= deadband_nxt;
      max_int_r    <= max_int_nxt;
      await_r      <= await_nxt;
      kept_value_r <= kept_value_nxt;
      kept_time_r  <= kept_time_nxt;
      upper_r      <= upper_nxt;
      lower_r      <= lower_nxt;
      seen_r       <= seen_nxt;
      stored_r     <= stored_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    kind_r      <= kind_nxt;
    value_r     <= value_nxt;
    stime_r     <= stime_nxt;
    st_r        <= st_nxt;
    su_r        <= su_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_store_r <= out_store_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_store_r;

  // an open door never has its upper edge below its lower edge
  a_door_order: assert property (@(posedge clk) disable iff (!rst_n)
    upper_r >= lower_r)
    else $error("door slopes crossed");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVU || state_r == S_DIVL))
    else $error("divider finished outside a door step");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EVAL))
    else $error("accepted item not evaluated");

  a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && (!out_tvalid_r || out_tready)) |=> (out_tvalid_r && state_r == S_IDLE))
    else $error("result not loaded");

  a_await_door: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (upper_r == '0 && lower_r == '0))
    else $error("door open before first kept sample");

endmodule
